// File: hw/rtl/xyz_to_oklab_converter_assert.svh
// assertion macros for the converter port-level checker
`ifndef XYZ_TO_OKLAB_CONVERTER_ASSERT_SVH
`define XYZ_TO_OKLAB_CONVERTER_ASSERT_SVH

// antecedent implies consequent, off while reset is low
`define XYZOK_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition never true outside reset
`define XYZOK_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/xyzok_pkg.sv
// types, matrix constants and pipeline sizes for the xyz to oklab converter
package xyzok_pkg;

  localparam int FRAC_BITS = 14;
  localparam int COEF_BITS = 30;
  localparam int IN_W      = 16;
  localparam int CONE_W    = 31;
  localparam int LAB_W     = 34;
  localparam int PROD_W    = 47;
  localparam int LIM_W     = 48;
  localparam int ROOT_W    = 15;
  localparam int CBRT_BITS = 15;
  localparam int CBRT_LAT  = 2 * CBRT_BITS + 1;
  localparam int LPROD_W   = 50;
  localparam int ACC_W     = 52;
  localparam int Q_W       = 22;
  // input reg, products, sums, magnitude, cube root, products, sums, round, output
  localparam int LATENCY   = 4 + CBRT_LAT + 4;

  typedef struct packed {
    logic signed [IN_W-1:0] xyz_x;
    logic signed [IN_W-1:0] xyz_y;
    logic signed [IN_W-1:0] xyz_z;
  } xyz_t;

  typedef struct packed {
    logic signed [IN_W-1:0] lightness;
    logic signed [IN_W-1:0] green_red;
    logic signed [IN_W-1:0] blue_yellow;
  } lab_t;

  // ten-decimal coefficient scaled by 2^30, rounded
  function automatic longint q30(longint d);
    return (d * 64'sd1048576 + 64'sd4882812) / 64'sd9765625;
  endfunction

  localparam logic signed [CONE_W-1:0] CONE_M [9] = '{
    CONE_W'(q30(64'sd8189330101)), CONE_W'(q30(64'sd3618667424)),
    CONE_W'(-q30(64'sd1288597137)),
    CONE_W'(q30(64'sd329845436)),  CONE_W'(q30(64'sd9293118715)),
    CONE_W'(q30(64'sd361456387)),
    CONE_W'(q30(64'sd482003018)),  CONE_W'(q30(64'sd2643662691)),
    CONE_W'(q30(64'sd6338517070))
  };

  localparam logic signed [LAB_W-1:0] LAB_M [9] = '{
    LAB_W'(q30(64'sd2104542553)),  LAB_W'(q30(64'sd7936177850)),
    LAB_W'(-q30(64'sd40720468)),
    LAB_W'(q30(64'sd19779984951)), LAB_W'(-q30(64'sd24285922050)),
    LAB_W'(q30(64'sd4505937099)),
    LAB_W'(q30(64'sd259040371)),   LAB_W'(q30(64'sd7827717662)),
    LAB_W'(-q30(64'sd8086757660))
  };

endpackage

// File: hw/rtl/xyz_to_oklab_converter.sv
// xyz (d65) to oklab converter top level
// a result shows on lab_o with valid_o high; the valid chain is as deep as the data path
// throughput: one item per cycle, busy is held low; the 31-stage cube root sets the depth
// the receiver cannot stall: each result is on the ports for exactly one cycle
// reset clears the valid chain only; data registers run freely
module xyz_to_oklab_converter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  xyzok_pkg::xyz_t xyz_i,
  output logic            valid_o,
  output xyzok_pkg::lab_t lab_o
);

  localparam int PW = xyzok_pkg::PROD_W;
  localparam int LW = xyzok_pkg::LIM_W;
  localparam int QP = xyzok_pkg::LPROD_W;
  localparam int AW = xyzok_pkg::ACC_W;
  localparam int QW = xyzok_pkg::Q_W;
  localparam int CB = xyzok_pkg::COEF_BITS;
  localparam int OW = xyzok_pkg::IN_W;

  xyzok_pkg::xyz_t      in_q;
  logic signed [PW-1:0] prod_q  [9];
  logic signed [LW-1:0] lms_q   [3];
  logic [LW-1:0]        lim_q   [3];
  logic                 neg_q   [3];
  logic signed [OW-1:0] root    [3];
  logic signed [QP-1:0] lprod_q [9];
  logic signed [AW-1:0] acc_q   [3];
  logic [QW-1:0]        q_q     [3];
  logic                 qneg_q  [3];
  logic signed [OW-1:0] res_d   [3];
  logic [xyzok_pkg::LATENCY-1:0] vld_q;
  logic signed [OW-1:0] xyz_v [3];

  assign busy = 1'b0;

  assign xyz_v[0] = in_q.xyz_x;
  assign xyz_v[1] = in_q.xyz_y;
  assign xyz_v[2] = in_q.xyz_z;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[xyzok_pkg::LATENCY-2:0], start & ~busy};
    end
  end

  assign valid_o = vld_q[xyzok_pkg::LATENCY-1];

  // capture the item, cone products, lms sums, magnitude and limit
  always_ff @(posedge clk_i) begin
    in_q <= xyz_i;
    for (int k = 0; k < 9; k++) begin
      prod_q[k] <= PW'(xyzok_pkg::CONE_M[k]) * PW'(xyz_v[k % 3]);
    end
    for (int i = 0; i < 3; i++) begin
      lms_q[i] <= LW'(prod_q[3*i]) + LW'(prod_q[3*i+1]) + LW'(prod_q[3*i+2]);
      neg_q[i] <= lms_q[i][LW-1];
      if (lms_q[i][LW-1]) begin
        lim_q[i] <= LW'(-lms_q[i]) << 1;
      end else begin
        lim_q[i] <= LW'(lms_q[i]) << 1;
      end
    end
  end

  // one cube root lane per lms component
  for (genvar i = 0; i < 3; i++) begin : g_root
    xyzok_cbrt u_cbrt (
      .clk_i  (clk_i),
      .lim_i  (lim_q[i]),
      .neg_i  (neg_q[i]),
      .root_o (root[i])
    );
  end

  // lab products, sums, rounding of the magnitude
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 9; k++) begin
      lprod_q[k] <= QP'(xyzok_pkg::LAB_M[k]) * QP'(root[k % 3]);
    end
    for (int i = 0; i < 3; i++) begin
      acc_q[i]  <= AW'(lprod_q[3*i]) + AW'(lprod_q[3*i+1]) + AW'(lprod_q[3*i+2]);
      qneg_q[i] <= acc_q[i][AW-1];
      if (acc_q[i][AW-1]) begin
        q_q[i] <= QW'((AW'(-acc_q[i]) + (AW'(1) << (CB - 1))) >> CB);
      end else begin
        q_q[i] <= QW'((AW'(acc_q[i]) + (AW'(1) << (CB - 1))) >> CB);
      end
    end
  end

  // saturate to the 16-bit range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (qneg_q[i]) begin
        res_d[i] = (q_q[i] > QW'(32768)) ? -16'sd32768 : -$signed(OW'(q_q[i]));
      end else begin
        res_d[i] = (q_q[i] > QW'(32767)) ? 16'sd32767 : $signed(OW'(q_q[i]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lab_o.lightness   <= res_d[0];
    lab_o.green_red   <= res_d[1];
    lab_o.blue_yellow <= res_d[2];
  end

endmodule

// File: hw/rtl/xyzok_cbrt.sv
// pipelined signed cube root, one result bit per two stages
module xyzok_cbrt (
  input  logic                               clk_i,
  input  logic [xyzok_pkg::LIM_W-1:0]        lim_i,
  input  logic                               neg_i,
  output logic signed [xyzok_pkg::IN_W-1:0]  root_o
);

  localparam int NB = xyzok_pkg::CBRT_BITS;
  localparam int RW = xyzok_pkg::ROOT_W;
  localparam int LW = xyzok_pkg::LIM_W;

  logic [RW-1:0]   r_in   [NB];
  logic [LW-1:0]   lim_in [NB];
  logic            neg_in [NB];
  logic [RW-1:0]   ra_q   [NB];
  logic [RW:0]     ma_q   [NB];
  logic [2*RW+1:0] sqa_q  [NB];
  logic [LW-1:0]   lima_q [NB];
  logic            nega_q [NB];
  logic [RW-1:0]   rb_q   [NB];
  logic [LW-1:0]   limb_q [NB];
  logic            negb_q [NB];

  for (genvar j = 0; j < NB; j++) begin : g_bit
    localparam logic [RW-1:0] BitMask = RW'(1) << (NB - 1 - j);
    logic [RW:0] m_d;
    logic [LW-1:0] cube;

    // chain input
    if (j == 0) begin : g_first
      assign r_in[j]   = '0;
      assign lim_in[j] = lim_i;
      assign neg_in[j] = neg_i;
    end else begin : g_next
      assign r_in[j]   = rb_q[j-1];
      assign lim_in[j] = limb_q[j-1];
      assign neg_in[j] = negb_q[j-1];
    end

    // odd midpoint 2c-1 of the trial root
    assign m_d = {r_in[j] | BitMask, 1'b0} - (RW+1)'(1);

    // square the midpoint
    always_ff @(posedge clk_i) begin
      ra_q[j]   <= r_in[j];
      ma_q[j]   <= m_d;
      sqa_q[j]  <= (2*RW+2)'(m_d) * (2*RW+2)'(m_d);
      lima_q[j] <= lim_in[j];
      nega_q[j] <= neg_in[j];
    end

    // cube and keep the bit when it stays within the limit
    assign cube = LW'(sqa_q[j]) * LW'(ma_q[j]);

    always_ff @(posedge clk_i) begin
      rb_q[j]   <= (cube <= lima_q[j]) ? (ra_q[j] | BitMask) : ra_q[j];
      limb_q[j] <= lima_q[j];
      negb_q[j] <= nega_q[j];
    end
  end

  // apply the sign
  always_ff @(posedge clk_i) begin
    if (negb_q[NB-1]) begin
      root_o <= -$signed({1'b0, rb_q[NB-1]});
    end else begin
      root_o <= $signed({1'b0, rb_q[NB-1]});
    end
  end

endmodule

// File: hw/rtl/xyzok_checker.sv
// port-level checker for the xyz to oklab converter, bound to the top level
`include "xyz_to_oklab_converter_assert.svh"

module xyzok_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input xyzok_pkg::xyz_t xyz_i,
  input logic            valid_o,
  input xyzok_pkg::lab_t lab_o
);

  localparam int Lat = xyzok_pkg::LATENCY;

  logic acc;
  logic zero_in;
  logic zero_out;

  assign acc      = start & ~busy;
  assign zero_in  = (xyz_i == '0);
  assign zero_out = (lab_o == '0);

  // the converter never holds items off
  `XYZOK_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy)
  // every accepted item comes out after the pipeline depth
  `XYZOK_ASSERT_IMPL(a_item_out, clk_i, rst_ni, acc, ##Lat valid_o)
  // black in gives zero lab out
  `XYZOK_ASSERT_IMPL(a_zero, clk_i, rst_ni, acc && zero_in, ##Lat zero_out)
  // no result without an item accepted at the right time
  `XYZOK_ASSERT_IMPL(a_no_extra, clk_i, rst_ni, valid_o, $past(acc, Lat))

endmodule

bind xyz_to_oklab_converter xyzok_checker u_xyzok_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .xyz_i   (xyz_i),
  .valid_o (valid_o),
  .lab_o   (lab_o)
);

// File: bench/xyz_to_oklab_converter_checker.sv
// checker for the xyz to oklab converter: predicts each result and compares it
module xyz_to_oklab_converter_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  xyzok_pkg::xyz_t xyz_i,
  input  logic            valid_i,
  input  xyzok_pkg::lab_t lab_i,
  output int              fail_count_o,
  output int              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCALE_BITS = 30;
  localparam int ROOT_SEARCH_BITS = 20;

  xyzok_pkg::lab_t lab_queue[$];

  // ten-decimal coefficient to a 2^30 scaled integer
  function automatic longint coef_q30(longint d);
    return (d * 64'sd1048576 + 64'sd4882812) / 64'sd9765625;
  endfunction

  // rounded sign-preserving cube root, lms scaled by 2^44, root by 2^14
  function automatic longint lms_cube_root(longint s);
    longint unsigned mag;
    longint unsigned lim;
    longint unsigned r;
    longint unsigned c;
    longint unsigned m;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    // the 8x lifts the search to odd half steps; shift by 2 = 30 - 2*14
    lim = (mag * 8) >> (SCALE_BITS - 2 * xyzok_pkg::FRAC_BITS);
    r = 0;
    for (int b = ROOT_SEARCH_BITS - 1; b >= 0; b--) begin
      c = r | (64'd1 << b);
      m = 2 * c - 1;
      if (m * m * m <= lim) r = c;
    end
    return (s < 0) ? -longint'(r) : longint'(r);
  endfunction

  // round half away from zero and clamp to 16 bits
  function automatic logic signed [15:0] round_clamp(longint acc);
    longint unsigned mag;
    longint unsigned q;
    mag = (acc < 0) ? longint'(-acc) : longint'(acc);
    q = (mag + (64'd1 << (SCALE_BITS - 1))) >> SCALE_BITS;
    if (acc < 0) return (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
    return (q > 32767) ? 16'sd32767 : 16'(q);
  endfunction

  function automatic xyzok_pkg::lab_t predict_lab(xyzok_pkg::xyz_t c);
    longint cone[9];
    longint labm[9];
    longint xyz[3];
    longint root[3];
    longint acc;
    xyzok_pkg::lab_t res;
    cone = '{coef_q30(64'sd8189330101), coef_q30(64'sd3618667424),
             -coef_q30(64'sd1288597137),
             coef_q30(64'sd329845436),  coef_q30(64'sd9293118715),
             coef_q30(64'sd361456387),
             coef_q30(64'sd482003018),  coef_q30(64'sd2643662691),
             coef_q30(64'sd6338517070)};
    labm = '{coef_q30(64'sd2104542553),  coef_q30(64'sd7936177850),
             -coef_q30(64'sd40720468),
             coef_q30(64'sd19779984951), -coef_q30(64'sd24285922050),
             coef_q30(64'sd4505937099),
             coef_q30(64'sd259040371),   coef_q30(64'sd7827717662),
             -coef_q30(64'sd8086757660)};
    xyz[0] = c.xyz_x;
    xyz[1] = c.xyz_y;
    xyz[2] = c.xyz_z;
    // cone response, then compress
    for (int i = 0; i < 3; i++)
      root[i] = lms_cube_root(cone[3*i] * xyz[0] + cone[3*i+1] * xyz[1]
                              + cone[3*i+2] * xyz[2]);
    acc = labm[0] * root[0] + labm[1] * root[1] + labm[2] * root[2];
    res.lightness = round_clamp(acc);
    acc = labm[3] * root[0] + labm[4] * root[1] + labm[5] * root[2];
    res.green_red = round_clamp(acc);
    acc = labm[6] * root[0] + labm[7] * root[1] + labm[8] * root[2];
    res.blue_yellow = round_clamp(acc);
    return res;
  endfunction

  assign pending_o = lab_queue.size();

  // record accepted items, compare results in order
  always @(posedge clk_i or negedge rst_ni) begin
    xyzok_pkg::lab_t want;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (start_i && !busy_i) lab_queue.push_back(predict_lab(xyz_i));
      if (valid_i) begin
        if (lab_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $realtime, lab_i);
          errs++;
        end else begin
          want = lab_queue.pop_front();
          if (lab_i.lightness !== want.lightness) begin
            $display("%0t: lightness expected %0d actual %0d", $realtime,
                     want.lightness, lab_i.lightness);
            errs++;
          end
          if (lab_i.green_red !== want.green_red) begin
            $display("%0t: green_red expected %0d actual %0d", $realtime,
                     want.green_red, lab_i.green_red);
            errs++;
          end
          if (lab_i.blue_yellow !== want.blue_yellow) begin
            $display("%0t: blue_yellow expected %0d actual %0d", $realtime,
                     want.blue_yellow, lab_i.blue_yellow);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

// File: bench/xyz_to_oklab_converter_tb.sv
// testbench top for the xyz to oklab converter: stimulus and verdict
module xyz_to_oklab_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  xyzok_pkg::xyz_t xyz_i = '0;
  logic valid_o;
  xyzok_pkg::lab_t lab_o;
  int fail_count;
  int pending;
  int cycles = 0;
  int burst_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  xyz_to_oklab_converter uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .xyz_i(xyz_i), .valid_o(valid_o), .lab_o(lab_o)
  );

  xyz_to_oklab_converter_checker checker_inst (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy),
    .xyz_i(xyz_i), .valid_i(valid_o), .lab_i(lab_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // timeout guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // hand one item over, idling between bursts
  task automatic send_item(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z);
    bit took;
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start = 1'b1;
    xyz_i = '{x, y, z};
    took = 1'b0;
    while (!took) begin
      @(posedge clk_i);
      took = !busy;
      @(negedge clk_i);
    end
  endtask

  // one random channel value: plausible colours, full range or single bits
  function automatic logic signed [15:0] rand_channel();
    case ($urandom_range(0, 3)) inside
      0, 1: return 16'($urandom_range(0, 18000));
      2: return 16'($urandom());
      default: return 16'sd1 <<< $urandom_range(0, 15);
    endcase
  endfunction

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed corners: zero, extremes, white, unit steps, sign mixes
    send_item(0, 0, 0);
    send_item(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_item(-16'sd32768, -16'sd32768, -16'sd32768);
    send_item(16'sh7fff, 0, 0);
    send_item(0, 16'sh7fff, 0);
    send_item(0, 0, 16'sh7fff);
    send_item(-16'sd32768, 0, 0);
    send_item(0, -16'sd32768, 0);
    send_item(0, 0, -16'sd32768);
    send_item(15579, 16384, 17841);
    send_item(1, 1, 1);
    send_item(-1, -1, -1);
    send_item(1, 0, 0);
    send_item(16'sh7fff, -16'sd32768, 16'sh7fff);
    send_item(-16'sd32768, 16'sh7fff, -16'sd32768);
    send_item(16'sh5555, 16'shaaaa, 16'sh5555);
    send_item(16'shaaaa, 16'sh5555, 16'shaaaa);
    send_item(16384, 0, 0);
    send_item(0, 16384, 0);
    send_item(0, 0, 16384);

    for (int n = 0; n < RANDOM_ITEMS; n++)
      send_item(rand_channel(), rand_channel(), rand_channel());
    start = 1'b0;

    // drain
    while (pending != 0) @(negedge clk_i);
    repeat (xyzok_pkg::LATENCY + 5) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
